// ===== hdl/per_user_share_throttle_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PER_USER_SHARE_THROTTLE_DEFINES_SVH
`define PER_USER_SHARE_THROTTLE_DEFINES_SVH

// Checked only while reset is low.
`define PUST_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define PUST_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/pust_pkg.sv =====
package pust_pkg;

   localparam int USER_SLOTS = 1024;
   localparam int SLOT_W     = $clog2(USER_SLOTS);
   localparam int CNT_W      = $clog2(USER_SLOTS + 1);
   localparam int RECIP      = (1 << 20) / USER_SLOTS;

   localparam logic signed [31:0] BOOT_BYTE_CREDIT = 32'sd102400;
   localparam logic signed [31:0] BOOT_OP_CREDIT   = 32'sd10;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OPS_PER_INTERVAL   = 2'd1;

   localparam logic [4:0] DIV_LAST_STEP = 5'd31;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_REQ,
      OP_TICK
   } pust_op_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_OWN,
      S_WALK,
      S_SCAN,
      S_DIVB,
      S_DIVO,
      S_FILL
   } pust_state_type;

   typedef struct packed {
      pust_op_type       op;
      logic [SLOT_W-1:0] uid;
      logic [30:0]       ask_bytes;
      logic [15:0]       ask_ops;
   } pust_entry_type;

   typedef struct packed {
      logic clearing;
   } pust_status_type;

   typedef struct packed {
      logic signed [31:0] share;
      logic [30:0]        ask;
   } take_type;

   function automatic take_type take_credit(logic signed [31:0] held, logic [30:0] ask);
      logic [32:0] diff;
      take_type    res;
      diff = {held[31], held} - {2'b00, ask};
      res.share = (diff[32] != diff[31]) ? 32'sh8000_0000 : diff[31:0];
      if (!held[31] && (held != 32'sd0)) begin
         res.ask = (held[30:0] < ask) ? (ask - held[30:0]) : 31'd0;
      end else begin
         res.ask = ask;
      end
      return res;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_of(logic [9:0] idx);
      logic [29:0] prod;
      logic [31:0] r;
      if (USER_SLOTS >= 1024) begin
         r = 32'(idx);
      end else begin
         prod = 30'(idx) * 30'(RECIP);
         r = 32'(idx) - 32'(prod[29:20]) * 32'(USER_SLOTS);
         if (r >= 32'(USER_SLOTS)) begin
            r = r - 32'(USER_SLOTS);
         end
      end
      return SLOT_W'(r);
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] idx);
      return (idx == SLOT_W'(USER_SLOTS - 1)) ? '0 : idx + 1'b1;
   endfunction

endpackage

// ===== hdl/pust_ram.sv =====
module pust_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

// ===== hdl/pust_div.sv =====
module pust_div
   import pust_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  dividend,
   input  logic [CNT_W-1:0]    divisor,
   output logic                done,
   output logic signed [31:0]  quotient
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [4:0]         step_ff, step_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   dvs_ff, dvs_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [31:0]        quo_ff, quo_in;
   logic signed [31:0] res_ff, res_in;
   logic [CNT_W:0]     shifted;
   logic [CNT_W:0]     diff;
   logic               fits;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      res_in  = res_ff;
      if (busy_ff) begin
         rem_in  = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in  = {quo_ff[30:0], fits};
         step_in = step_ff + 5'd1;
         if (step_ff == DIV_LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -quo_in : quo_in;
         end
      end else if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = dividend[31];
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend[31] ? -dividend : dividend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      neg_ff  <= neg_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

// ===== hdl/pust_front.sv =====
module pust_front
   import pust_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            kind,
   input  logic [9:0]      user_index,
   input  logic [30:0]     request_bytes,
   input  logic [15:0]     request_ops,
   input  logic            bytes_on,
   input  logic            ops_on,
   input  pust_status_type status,
   input  logic            pop,
   output pust_entry_type  entry,
   output logic            empty,
   output logic            busy
);

   pust_entry_type q_ff [2];
   logic           wr_ff, wr_in;
   logic           rd_ff, rd_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           push;
   pust_entry_type item;

   always_comb begin
      item.uid       = slot_of(user_index);
      item.ask_bytes = bytes_on ? request_bytes : 31'd0;
      item.ask_ops   = ops_on ? request_ops : 16'd0;
      if (kind) begin
         item.op = OP_TICK;
      end else if ((item.ask_bytes != 31'd0) || (item.ask_ops != 16'd0)) begin
         item.op = OP_REQ;
      end else begin
         item.op = OP_NOP;
      end
   end

   assign busy  = (cnt_ff == 2'd2) || status.clearing;
   assign empty = (cnt_ff == 2'd0);
   assign push  = start && !busy;
   assign entry = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= item;
      end
   end

endmodule

// ===== hdl/pust_back.sv =====
module pust_back
   import pust_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  pust_entry_type     entry,
   input  logic               empty,
   output logic               pop,
   input  logic signed [31:0] bytes_per_interval,
   input  logic signed [31:0] ops_per_interval,
   output pust_status_type    status,
   output logic               rsp_valid,
   output logic [30:0]        rsp_bytes_left,
   output logic [15:0]        rsp_ops_left,
   output logic               rsp_must_wait,
   output logic [10:0]        rsp_active_count,
   output logic signed [31:0] rsp_round_byte_grant
);

   pust_state_type     state_ff, state_in;
   pust_op_type        op_ff, op_in;
   logic [SLOT_W-1:0]  uid_ff, uid_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [30:0]        askb_ff, askb_in;
   logic [15:0]        asko_ff, asko_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [31:0] grant_b_ff, grant_b_in;
   logic signed [31:0] grant_o_ff, grant_o_in;
   logic signed [31:0] last_ff, last_in;
   logic               rv_ff, rv_in;
   logic [30:0]        rb_ff, rb_in;
   logic [15:0]        ro_ff, ro_in;
   logic               rw_ff, rw_in;
   logic [10:0]        ra_ff, ra_in;

   logic               p_we, s_we;
   logic [SLOT_W-1:0]  waddr, raddr;
   logic [63:0]        p_wdata, s_wdata, p_rdata, s_rdata;
   logic               div_start, div_done;
   logic signed [31:0] dividend, quotient;
   logic [CNT_W-1:0]   divisor;

   logic signed [31:0] pb, po, sb, so;
   take_type           t_pb, t_sb, t_po, t_so, w_sb, w_so;
   logic [SLOT_W-1:0]  nxt_idx, nxt_uid;
   logic               last_slot, act;
   logic [CNT_W-1:0]   cnt_scan;
   logic [31:0]        cnt_wide;
   logic [10:0]        act_sat;

   pust_ram #(.DEPTH(USER_SLOTS), .WIDTH(64)) u_pmem (
      .clock(clock), .we(p_we), .waddr(waddr), .wdata(p_wdata),
      .raddr(raddr), .rdata(p_rdata)
   );

   pust_ram #(.DEPTH(USER_SLOTS), .WIDTH(64)) u_smem (
      .clock(clock), .we(s_we), .waddr(waddr), .wdata(s_wdata),
      .raddr(raddr), .rdata(s_rdata)
   );

   pust_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dividend),
      .divisor(divisor), .done(div_done), .quotient(quotient)
   );

   assign pb = p_rdata[63:32];
   assign po = p_rdata[31:0];
   assign sb = s_rdata[63:32];
   assign so = s_rdata[31:0];

   assign t_pb = take_credit(pb, askb_ff);
   assign t_sb = take_credit(sb, t_pb.ask);
   assign t_po = take_credit(po, 31'(asko_ff));
   assign t_so = take_credit(so, t_po.ask);
   assign w_sb = take_credit(sb, askb_ff);
   assign w_so = take_credit(so, 31'(asko_ff));

   assign nxt_idx   = next_slot(idx_ff);
   assign nxt_uid   = next_slot(uid_ff);
   assign last_slot = (idx_ff == SLOT_W'(USER_SLOTS - 1));
   assign act       = (pb != last_ff);
   assign cnt_scan  = act ? cnt_ff + 1'b1 : cnt_ff;
   assign cnt_wide  = 32'(cnt_ff);
   assign act_sat   = (cnt_wide > 32'd2047) ? 11'd2047 : cnt_wide[10:0];

   assign status.clearing = (state_ff == S_CLEAR);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (last_slot) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (!empty) begin
               case (entry.op)
                  OP_REQ:  state_in = S_OWN;
                  OP_TICK: state_in = S_SCAN;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_OWN: begin
            if (((t_sb.ask != 31'd0) || (t_so.ask != 31'd0)) && (nxt_uid != uid_ff)) begin
               state_in = S_WALK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if ((nxt_idx == uid_ff) || ((w_sb.ask == 31'd0) && (w_so.ask == 31'd0))) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (last_slot) state_in = S_DIVB;
         end
         S_DIVB: begin
            if (div_done) state_in = S_DIVO;
         end
         S_DIVO: begin
            if (div_done) state_in = S_FILL;
         end
         S_FILL: begin
            if (last_slot) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      op_in      = op_ff;
      uid_in     = uid_ff;
      idx_in     = idx_ff;
      askb_in    = askb_ff;
      asko_in    = asko_ff;
      cnt_in     = cnt_ff;
      grant_b_in = grant_b_ff;
      grant_o_in = grant_o_ff;
      last_in    = last_ff;
      rv_in      = 1'b0;
      rb_in      = rb_ff;
      ro_in      = ro_ff;
      rw_in      = rw_ff;
      ra_in      = ra_ff;
      p_we       = 1'b0;
      s_we       = 1'b0;
      waddr      = idx_ff;
      raddr      = '0;
      p_wdata    = {last_ff, grant_o_ff};
      s_wdata    = '0;
      pop        = 1'b0;
      div_start  = 1'b0;
      dividend   = bytes_per_interval;
      divisor    = (cnt_scan == '0) ? CNT_W'(1) : cnt_scan;
      case (state_ff)
         S_CLEAR: begin
            p_we    = 1'b1;
            s_we    = 1'b1;
            p_wdata = {BOOT_BYTE_CREDIT, BOOT_OP_CREDIT};
            idx_in  = nxt_idx;
         end
         S_IDLE: begin
            raddr = (entry.op == OP_REQ) ? entry.uid : '0;
            if (!empty) begin
               pop     = 1'b1;
               op_in   = entry.op;
               uid_in  = entry.uid;
               askb_in = entry.ask_bytes;
               asko_in = entry.ask_ops;
               idx_in  = '0;
               cnt_in  = '0;
               if (entry.op == OP_NOP) begin
                  rv_in = 1'b1;
                  rb_in = '0;
                  ro_in = '0;
                  rw_in = 1'b0;
                  ra_in = '0;
               end
            end
         end
         S_OWN: begin
            p_we    = 1'b1;
            s_we    = 1'b1;
            waddr   = uid_ff;
            p_wdata = {t_pb.share, t_po.share};
            s_wdata = {t_sb.share, t_so.share};
            askb_in = t_sb.ask;
            asko_in = t_so.ask[15:0];
            idx_in  = nxt_uid;
            raddr   = nxt_uid;
            if (state_in == S_IDLE) begin
               rv_in = 1'b1;
               rb_in = t_sb.ask;
               ro_in = t_so.ask[15:0];
               rw_in = (t_sb.ask != 31'd0) || (t_so.ask != 31'd0);
               ra_in = '0;
            end
         end
         S_WALK: begin
            s_we    = 1'b1;
            s_wdata = {w_sb.share, w_so.share};
            askb_in = w_sb.ask;
            asko_in = w_so.ask[15:0];
            idx_in  = nxt_idx;
            raddr   = nxt_idx;
            if (state_in == S_IDLE) begin
               rv_in = 1'b1;
               rb_in = w_sb.ask;
               ro_in = w_so.ask[15:0];
               rw_in = (w_sb.ask != 31'd0) || (w_so.ask != 31'd0);
               ra_in = '0;
            end
         end
         S_SCAN: begin
            s_we    = act;
            s_wdata = {(pb[31] ? sb : pb), (po[31] ? so : po)};
            cnt_in  = cnt_scan;
            idx_in  = nxt_idx;
            raddr   = nxt_idx;
            div_start = last_slot;
         end
         S_DIVB: begin
            dividend = ops_per_interval;
            divisor  = (cnt_ff == '0) ? CNT_W'(1) : cnt_ff;
            if (div_done) begin
               grant_b_in = quotient;
               div_start  = 1'b1;
            end
         end
         S_DIVO: begin
            if (div_done) begin
               grant_o_in = quotient;
               last_in    = grant_b_ff;
               idx_in     = '0;
            end
         end
         S_FILL: begin
            p_we   = 1'b1;
            idx_in = nxt_idx;
            if (last_slot) begin
               rv_in = 1'b1;
               rb_in = '0;
               ro_in = '0;
               rw_in = 1'b0;
               ra_in = act_sat;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         last_ff  <= BOOT_BYTE_CREDIT;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         last_ff  <= last_in;
         rv_ff    <= rv_in;
      end
      op_ff      <= op_in;
      uid_ff     <= uid_in;
      askb_ff    <= askb_in;
      asko_ff    <= asko_in;
      cnt_ff     <= cnt_in;
      grant_b_ff <= grant_b_in;
      grant_o_ff <= grant_o_in;
      rb_ff      <= rb_in;
      ro_ff      <= ro_in;
      rw_ff      <= rw_in;
      ra_ff      <= ra_in;
   end

   assign rsp_valid            = rv_ff;
   assign rsp_bytes_left       = rb_ff;
   assign rsp_ops_left         = ro_ff;
   assign rsp_must_wait        = rw_ff;
   assign rsp_active_count     = ra_ff;
   assign rsp_round_byte_grant = last_ff;

endmodule

// ===== hdl/per_user_share_throttle.sv =====
// A request that asks nothing gets its result strobe straight from the idle state; any other
// request is served by its own slot first, then by the secondary shares of the slots after it.
// An interval tick scans and then refills the credit memories, one slot per cycle,
// with a divide for each budget between them.
// Up to two requests queue ahead of the credit engine; results cannot be stalled.
// After reset, busy stays high while the credit memories are cleared.
module per_user_share_throttle
   import pust_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_kind,
   input  logic [9:0]           req_user_index,
   input  logic [30:0]          req_request_bytes,
   input  logic [15:0]          req_request_ops,
   output logic                 rsp_valid,
   output logic [30:0]          rsp_bytes_left,
   output logic [15:0]          rsp_ops_left,
   output logic                 rsp_must_wait,
   output logic [10:0]          rsp_active_count,
   output logic signed [31:0]   rsp_round_byte_grant,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   logic signed [31:0] bytes_per_interval_ff, bytes_per_interval_in;
   logic signed [31:0] ops_per_interval_ff, ops_per_interval_in;
   pust_entry_type     entry;
   pust_status_type    status;
   logic               empty;
   logic               pop;

   assign csr_ready = 1'b1;

   always_comb begin
      bytes_per_interval_in = bytes_per_interval_ff;
      ops_per_interval_in   = ops_per_interval_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BYTES_PER_INTERVAL: bytes_per_interval_in = csr_data;
            CSR_OPS_PER_INTERVAL:   ops_per_interval_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_per_interval_ff <= -32'sd1;
         ops_per_interval_ff   <= -32'sd1;
      end else begin
         bytes_per_interval_ff <= bytes_per_interval_in;
         ops_per_interval_ff   <= ops_per_interval_in;
      end
   end

   pust_front u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .kind(req_kind),
      .user_index(req_user_index),
      .request_bytes(req_request_bytes),
      .request_ops(req_request_ops),
      .bytes_on(!bytes_per_interval_ff[31]),
      .ops_on(!ops_per_interval_ff[31]),
      .status(status),
      .pop(pop),
      .entry(entry),
      .empty(empty),
      .busy(busy)
   );

   pust_back u_back (
      .clock(clock),
      .reset(reset),
      .entry(entry),
      .empty(empty),
      .pop(pop),
      .bytes_per_interval(bytes_per_interval_ff),
      .ops_per_interval(ops_per_interval_ff),
      .status(status),
      .rsp_valid(rsp_valid),
      .rsp_bytes_left(rsp_bytes_left),
      .rsp_ops_left(rsp_ops_left),
      .rsp_must_wait(rsp_must_wait),
      .rsp_active_count(rsp_active_count),
      .rsp_round_byte_grant(rsp_round_byte_grant)
   );

endmodule

// ===== hdl/pust_checker.sv =====
`include "per_user_share_throttle_defines.svh"

module pust_checker
   import pust_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [30:0] rsp_bytes_left,
   input logic [15:0] rsp_ops_left,
   input logic        rsp_must_wait,
   input logic [10:0] rsp_active_count
);

   `PUST_ASSERT(a_wait_flag,
      rsp_valid |-> (rsp_must_wait == ((rsp_bytes_left != 0) || (rsp_ops_left != 0))),
      "wait flag disagrees with the amounts left")
   `PUST_ASSERT(a_tick_clean, (rsp_valid && (rsp_active_count != 0)) |-> !rsp_must_wait,
      "tick result reports a wait")
   `PUST_ASSERT_ALWAYS(a_reset_busy, reset |=> busy, "block not busy after reset")
   `PUST_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result strobe right after reset")

endmodule

bind per_user_share_throttle pust_checker u_pust_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
   import pust_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic KIND_REQ  = 1'b0;
   localparam logic KIND_TICK = 1'b1;
   localparam int   SLOTS     = 1024;
   localparam longint CYCLE_LIMIT = 8000000;

   typedef struct {
      logic        kind;
      logic [9:0]  user;
      logic [30:0] bytes;
      logic [15:0] ops;
   } request_type;

   typedef struct {
      logic [30:0]        bytes_left;
      logic [15:0]        ops_left;
      logic               must_wait;
      logic [10:0]        active_count;
      logic signed [31:0] grant;
   } answer_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_kind;
   logic [9:0]           req_user_index;
   logic [30:0]          req_request_bytes;
   logic [15:0]          req_request_ops;
   logic                 rsp_valid;
   logic [30:0]          rsp_bytes_left;
   logic [15:0]          rsp_ops_left;
   logic                 rsp_must_wait;
   logic [10:0]          rsp_active_count;
   logic signed [31:0]   rsp_round_byte_grant;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_data;

   per_user_share_throttle u_top (.*);

   request_type pending_requests[$];
   answer_type  expected_answers[$];

   int     byte_primary[SLOTS];
   int     byte_secondary[SLOTS];
   int     op_primary[SLOTS];
   int     op_secondary[SLOTS];
   int     byte_grant;
   longint byte_budget;
   longint op_budget;

   int     mismatches;
   int     pushed_count;
   int     accepted_count;
   int     gap;
   bit     quiet;
   bit     took;
   longint cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   task automatic draw(inout int share, inout longint ask);
      longint held;
      held = share;
      share = clamp32(held - ask);
      if (held > 0) ask -= (held < ask) ? held : ask;
   endtask

   task automatic predict_answer(input request_type rq);
      answer_type ans;
      longint  want_b;
      longint  want_o;
      longint  active;
      longint  div;
      int      uid;
      int      s;
      int      op_grant;
      want_b = rq.bytes;
      want_o = rq.ops;
      uid = rq.user;
      active = 0;
      if (rq.kind == KIND_REQ) begin
         if (byte_budget < 0) want_b = 0;
         if (op_budget < 0) want_o = 0;
         if (want_b != 0 || want_o != 0) begin
            draw(byte_primary[uid], want_b);
            if (want_b != 0) draw(byte_secondary[uid], want_b);
            draw(op_primary[uid], want_o);
            if (want_o != 0) draw(op_secondary[uid], want_o);
            for (int i = 1; i < SLOTS && (want_b != 0 || want_o != 0); i++) begin
               s = (uid + i) % SLOTS;
               if (want_b != 0) draw(byte_secondary[s], want_b);
               if (want_o != 0) draw(op_secondary[s], want_o);
            end
         end
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            if (byte_primary[i] != byte_grant) begin
               active++;
               if (byte_primary[i] >= 0) byte_secondary[i] = byte_primary[i];
               if (op_primary[i] >= 0) op_secondary[i] = op_primary[i];
            end
         end
         div = (active != 0) ? active : 1;
         byte_grant = clamp32(byte_budget / div);
         op_grant = clamp32(op_budget / div);
         for (int i = 0; i < SLOTS; i++) begin
            byte_primary[i] = byte_grant;
            op_primary[i] = op_grant;
         end
         want_b = 0;
         want_o = 0;
      end
      ans.bytes_left = want_b[30:0];
      ans.ops_left = want_o[15:0];
      ans.must_wait = (want_b != 0 || want_o != 0);
      ans.active_count = (active > 2047) ? 11'd2047 : active[10:0];
      ans.grant = byte_grant;
      expected_answers.push_back(ans);
   endtask

   always @(negedge clock) begin
      request_type rq;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !took) begin
         start <= 1'b1;
      end else if (gap > 0) begin
         gap <= gap - 1;
         start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
         rq = pending_requests.pop_front();
         req_kind <= rq.kind;
         req_user_index <= rq.user;
         req_request_bytes <= rq.bytes;
         req_request_ops <= rq.ops;
         start <= 1'b1;
         if (!quiet && $urandom_range(0, 4) == 0) gap <= $urandom_range(1, 3);
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      request_type rq;
      answer_type  exp_ans;
      cycles <= cycles + 1;
      took = start && !busy && !reset;
      if (took) begin
         rq.kind = req_kind;
         rq.user = req_user_index;
         rq.bytes = req_request_bytes;
         rq.ops = req_request_ops;
         predict_answer(rq);
         accepted_count++;
      end
      if (rsp_valid && !reset) begin
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            exp_ans = expected_answers.pop_front();
            if (rsp_bytes_left !== exp_ans.bytes_left || rsp_ops_left !== exp_ans.ops_left ||
                rsp_must_wait !== exp_ans.must_wait ||
                rsp_active_count !== exp_ans.active_count ||
                rsp_round_byte_grant !== exp_ans.grant) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                           exp_ans.bytes_left, exp_ans.ops_left, exp_ans.must_wait,
                           exp_ans.active_count, exp_ans.grant, rsp_bytes_left,
                           rsp_ops_left, rsp_must_wait, rsp_active_count,
                           rsp_round_byte_grant);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_request(logic kind, logic [9:0] user, logic [30:0] b, logic [15:0] o);
      request_type rq;
      rq.kind = kind;
      rq.user = user;
      rq.bytes = b;
      rq.ops = o;
      pending_requests.push_back(rq);
      pushed_count++;
   endtask

   task automatic drain();
      while (accepted_count != pushed_count || expected_answers.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_BYTES_PER_INTERVAL) byte_budget = longint'(signed'(value));
      else if (idx == CSR_OPS_PER_INTERVAL) op_budget = longint'(signed'(value));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int count, int byte_span, int op_span);
      logic [9:0]  user;
      logic [30:0] b;
      logic [15:0] o;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 24) == 0) begin
            push_request(KIND_TICK, 10'($urandom), 31'($urandom), 16'($urandom));
         end else begin
            user = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
            case ($urandom_range(0, 19))
               0: b = 31'h7fffffff;
               1: b = 31'($urandom);
               2: b = '0;
               default: b = 31'($urandom_range(0, byte_span));
            endcase
            case ($urandom_range(0, 19))
               0: o = 16'hffff;
               1: o = 16'($urandom);
               2: o = '0;
               default: o = 16'($urandom_range(0, op_span));
            endcase
            push_request(KIND_REQ, user, b, o);
         end
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_REQ;
      req_user_index = '0;
      req_request_bytes = '0;
      req_request_ops = '0;
      csr_valid = 1'b0;
      csr_index = CSR_BYTES_PER_INTERVAL;
      csr_data = '0;
      mismatches = 0;
      pushed_count = 0;
      accepted_count = 0;
      gap = 0;
      quiet = 1'b0;
      took = 1'b0;
      cycles = 0;
      byte_budget = -1;
      op_budget = -1;
      byte_grant = 102400;
      for (int i = 0; i < SLOTS; i++) begin
         byte_primary[i] = 102400;
         byte_secondary[i] = 0;
         op_primary[i] = 10;
         op_secondary[i] = 0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_request(KIND_REQ, 10'd0, 31'h7fffffff, 16'hffff);
      push_request(KIND_REQ, 10'd1023, '0, '0);
      push_request(KIND_TICK, 10'd5, '0, '0);
      drain();

      write_reg(CSR_BYTES_PER_INTERVAL, 32'h7fffffff);
      write_reg(CSR_OPS_PER_INTERVAL, 32'h7fffffff);
      push_request(KIND_REQ, 10'd3, '0, '0);
      push_request(KIND_REQ, 10'd1023, 31'h7fffffff, 16'hffff);
      push_request(KIND_TICK, 10'd1023, 31'h7fffffff, 16'hffff);
      push_request(KIND_REQ, 10'd0, 31'h7fffffff, 16'hffff);
      push_request(KIND_REQ, 10'd0, 31'h7fffffff, 16'hffff);
      push_request(KIND_TICK, '0, '0, '0);
      push_request(KIND_TICK, '0, '0, '0);
      drain();

      write_reg(CSR_BYTES_PER_INTERVAL, 32'd0);
      write_reg(CSR_OPS_PER_INTERVAL, 32'd0);
      push_request(KIND_TICK, '0, '0, '0);
      push_request(KIND_REQ, 10'd512, 31'd1, 16'd0);
      push_request(KIND_REQ, 10'd513, 31'd0, 16'd1);
      push_request(KIND_REQ, 10'd514, 31'h7fffffff, 16'hffff);
      drain();

      write_reg(CSR_BYTES_PER_INTERVAL, 32'hffffffff);
      write_reg(CSR_OPS_PER_INTERVAL, 32'd100);
      push_request(KIND_TICK, '0, '0, '0);
      push_request(KIND_REQ, 10'd7, 31'd5000, 16'd50);
      push_request(KIND_REQ, 10'd7, 31'd5000, 16'd200);
      drain();

      write_reg(CSR_BYTES_PER_INTERVAL, 32'd1048576);
      write_reg(CSR_OPS_PER_INTERVAL, 32'd2000);
      push_request(KIND_TICK, '0, '0, '0);
      random_phase(300, 8192, 40);

      write_reg(CSR_BYTES_PER_INTERVAL, 32'h7fffffff);
      write_reg(CSR_OPS_PER_INTERVAL, 32'hffffffff);
      push_request(KIND_TICK, '0, '0, '0);
      random_phase(200, 1 << 20, 100);

      write_reg(CSR_BYTES_PER_INTERVAL, 32'd65536);
      write_reg(CSR_OPS_PER_INTERVAL, 32'd500);
      push_request(KIND_TICK, '0, '0, '0);
      random_phase(250, 4096, 20);

      quiet = 1'b1;
      write_reg(CSR_BYTES_PER_INTERVAL, 32'd4000000);
      write_reg(CSR_OPS_PER_INTERVAL, 32'd5000);
      push_request(KIND_TICK, '0, '0, '0);
      random_phase(180, 16384, 30);

      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
